### hw/rtl/hht_pkg.sv
package hht_pkg;

    localparam int SIDE_DEFAULT = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 32;

    localparam logic [7:0]         WEIGHT_BASE   = 8'd150;
    localparam logic [7:0]         WEIGHT_LIN    = 8'd5;
    localparam logic [7:0]         WEIGHT_CUTOFF = 8'd10;
    localparam logic signed [31:0] MAX_FLOOR     = 32'shC000_0000;

    typedef enum logic [2:0] {
        CMD_CREDIT   = 3'd0,
        CMD_PENALIZE = 3'd1,
        CMD_ADJUST   = 3'd2,
        CMD_AGE      = 3'd3,
        CMD_CLEAR    = 3'd4,
        CMD_SCORE    = 3'd5,
        CMD_MAX      = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_UPDATE,
        OP_READ,
        OP_AGE,
        OP_CLEAR,
        OP_MAX
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [32:0] operand;
    } item_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_CELL,
        BK_SWEEP,
        BK_DRAIN,
        BK_RESULT
    } bk_state_t;

    // max(0, 150 - 5d - d*d), nonzero only below depth 10
    function automatic logic [7:0] depth_weight(input logic [7:0] d);
        logic [15:0] w;
        w = 16'(WEIGHT_BASE) - 16'(d[3:0]) * 16'(WEIGHT_LIN) - 16'(d[3:0]) * 16'(d[3:0]);
        if (d < WEIGHT_CUTOFF)
        begin
            return w[7:0];
        end
        return 8'd0;
    endfunction

endpackage

### hw/rtl/history_heuristic_table_unit.sv
// history score table, SIDE x SIDE signed 32-bit cells addressed by column and row
// input stream s_*: one command per transfer; every command returns exactly one
// transfer on m_* (the cell for score, the maximum for max, zero otherwise)
// credit and penalize add or subtract the depth weight, adjust adds a signed
// amount, all saturating; cell commands on pass moves or off the table touch nothing
// cell commands (credit, penalize, adjust, score, unused code) use the idle and cell
// states of the back end: one memory read, then for the updates one write; the result
// passes the queue, the read data and output registers, one item at a time
// age, clear and max walk every cell, one cell per cycle
// a two-entry queue separates the decoding front end from the back end, so the input
// keeps accepting while a result waits in the output register
// when m_tready is low the result is held and the back end waits; the input stalls
// once the queue is full
// after reset the store is cleared by a pass over every cell, s_tready stays low
module history_heuristic_table_unit #(
    parameter int SIDE = hht_pkg::SIDE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[2:0], is_pass[3], col_index[8:4], row_index[13:9], search_depth[21:14],
    // adjust_amount[53:22], zero fill[55:54]
    input  logic [hht_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_value[31:0]
    output logic [hht_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(SIDE * SIDE);
    localparam int QW = AW + $bits(hht_pkg::item_t);

    logic           q_full, q_push, q_pop, q_valid, init_busy;
    logic [AW-1:0]  push_addr, head_addr;
    hht_pkg::item_t push_item, head_item;
    logic [QW-1:0]  head_data;

    hhtu_front #(.SIDE(SIDE)) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_addr    (push_addr),
        .q_item    (push_item)
    );

    hhtu_fifo #(.DATA_W(QW)) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({push_addr, push_item}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_data)
    );

    assign head_addr = head_data[QW-1 -: AW];
    assign head_item = hht_pkg::item_t'(head_data[$bits(hht_pkg::item_t)-1:0]);

    hhtu_back #(.SIDE(SIDE)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_addr    (head_addr),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### hw/rtl/hhtu_front.sv
module hhtu_front #(
    parameter int SIDE = hht_pkg::SIDE_DEFAULT,
    localparam int AW = $clog2(SIDE * SIDE)
) (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hht_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              q_full,
    input  logic                              init_busy,
    output logic                              q_push,
    output logic [AW-1:0]                     q_addr,
    output hht_pkg::item_t                    q_item
);

    localparam int IW = AW + 6;
    localparam logic [6:0] SIDE_V = 7'(SIDE);

    logic [2:0]         cmd;
    logic               is_pass;
    logic [4:0]         col_index;
    logic [4:0]         row_index;
    logic [7:0]         search_depth;
    logic signed [31:0] adjust_amount;
    logic               cell_ok;
    logic [IW-1:0]      idx_wide;
    logic [7:0]         weight;

    assign cmd           = s_tdata[2:0];
    assign is_pass       = s_tdata[3];
    assign col_index     = s_tdata[8:4];
    assign row_index     = s_tdata[13:9];
    assign search_depth  = s_tdata[21:14];
    assign adjust_amount = s_tdata[53:22];

    assign s_tready = !q_full && !init_busy;
    assign q_push   = s_tvalid && s_tready;

    assign cell_ok  = !is_pass && ({2'b00, col_index} < SIDE_V) && ({2'b00, row_index} < SIDE_V);
    assign idx_wide = IW'(col_index) * IW'(SIDE) + IW'(row_index);
    assign q_addr   = idx_wide[AW-1:0];
    assign weight   = hht_pkg::depth_weight(search_depth);

    always_comb
    begin
        q_item.op      = hht_pkg::OP_NOP;
        q_item.operand = '0;
        case (hht_pkg::cmd_t'(cmd))
            hht_pkg::CMD_CREDIT:
            begin
                q_item.op      = cell_ok ? hht_pkg::OP_UPDATE : hht_pkg::OP_NOP;
                q_item.operand = 33'(weight);
            end
            hht_pkg::CMD_PENALIZE:
            begin
                q_item.op      = cell_ok ? hht_pkg::OP_UPDATE : hht_pkg::OP_NOP;
                q_item.operand = -(33'(weight));
            end
            hht_pkg::CMD_ADJUST:
            begin
                q_item.op      = cell_ok ? hht_pkg::OP_UPDATE : hht_pkg::OP_NOP;
                q_item.operand = {adjust_amount[31], adjust_amount};
            end
            hht_pkg::CMD_AGE:   q_item.op = hht_pkg::OP_AGE;
            hht_pkg::CMD_CLEAR: q_item.op = hht_pkg::OP_CLEAR;
            hht_pkg::CMD_SCORE: q_item.op = cell_ok ? hht_pkg::OP_READ : hht_pkg::OP_NOP;
            hht_pkg::CMD_MAX:   q_item.op = hht_pkg::OP_MAX;
            default:            q_item.op = hht_pkg::OP_NOP;
        endcase
    end

endmodule

### hw/rtl/hhtu_fifo.sv
module hhtu_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    localparam int DEPTH = hht_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/hhtu_back.sv
module hhtu_back #(
    parameter int SIDE = hht_pkg::SIDE_DEFAULT,
    localparam int AW = $clog2(SIDE * SIDE)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic [AW-1:0]                   q_addr,
    input  hht_pkg::item_t                  q_item,
    output logic                            q_pop,
    output logic                            init_busy,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hht_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int CELLS = SIDE * SIDE;
    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

    logic signed [31:0] mem [CELLS];
    logic signed [31:0] rd_data_reg;

    hht_pkg::bk_state_t state_reg, state_next;
    hht_pkg::op_t       kind_reg, kind_next;
    logic signed [32:0] operand_reg, operand_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic signed [31:0] acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg, out_data_next;

    logic               rd_en, wr_en, load, out_free, sweep_op;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic signed [31:0] wr_data;
    logic [31:0]        load_data;
    logic signed [33:0] sum;
    logic signed [31:0] sat_sum;
    logic signed [32:0] half_pre;

    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign init_busy = (state_reg == hht_pkg::BK_INIT);
    assign sweep_op  = (q_item.op == hht_pkg::OP_AGE) || (q_item.op == hht_pkg::OP_CLEAR)
                    || (q_item.op == hht_pkg::OP_MAX);

    // saturating cell update
    assign sum = {{2{rd_data_reg[31]}}, rd_data_reg} + {operand_reg[32], operand_reg};
    always_comb
    begin
        if (!sum[33] && (sum[32:31] != 2'b00))
        begin
            sat_sum = 32'sh7FFF_FFFF;
        end
        else if (sum[33] && (sum[32:31] != 2'b11))
        begin
            sat_sum = 32'sh8000_0000;
        end
        else
        begin
            sat_sum = sum[31:0];
        end
    end

    // halve toward zero
    assign half_pre = {rd_data_reg[31], rd_data_reg} + 33'(rd_data_reg[31]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hht_pkg::BK_INIT:
            begin
                if (ptr_reg == LAST)
                begin
                    state_next = hht_pkg::BK_IDLE;
                end
            end
            hht_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = sweep_op ? hht_pkg::BK_SWEEP : hht_pkg::BK_CELL;
                end
            end
            hht_pkg::BK_CELL:
            begin
                if (out_free)
                begin
                    state_next = hht_pkg::BK_IDLE;
                end
            end
            hht_pkg::BK_SWEEP:
            begin
                if (ptr_reg == LAST)
                begin
                    state_next = hht_pkg::BK_DRAIN;
                end
            end
            hht_pkg::BK_DRAIN: state_next = hht_pkg::BK_RESULT;
            hht_pkg::BK_RESULT:
            begin
                if (out_free)
                begin
                    state_next = hht_pkg::BK_IDLE;
                end
            end
            default: state_next = hht_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = '0;
        load           = 1'b0;
        load_data      = '0;
        kind_next      = kind_reg;
        operand_next   = operand_reg;
        addr_next      = addr_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        acc_next       = acc_reg;
        case (state_reg)
            hht_pkg::BK_INIT:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            hht_pkg::BK_IDLE:
            begin
                q_pop        = q_valid;
                kind_next    = q_item.op;
                operand_next = q_item.operand;
                addr_next    = q_addr;
                ptr_next     = '0;
                acc_next     = hht_pkg::MAX_FLOOR;
                rd_en        = q_valid && !sweep_op;
                rd_addr      = q_addr;
            end
            hht_pkg::BK_CELL:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    load_data = (kind_reg == hht_pkg::OP_READ) ? rd_data_reg : '0;
                    if (kind_reg == hht_pkg::OP_UPDATE)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = addr_reg;
                        wr_data = sat_sum;
                    end
                end
            end
            hht_pkg::BK_SWEEP, hht_pkg::BK_DRAIN:
            begin
                if (state_reg == hht_pkg::BK_SWEEP)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    if (kind_reg == hht_pkg::OP_CLEAR)
                    begin
                        wr_en     = 1'b1;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        pend_next      = 1'b1;
                        pend_addr_next = ptr_reg;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (kind_reg == hht_pkg::OP_AGE)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pend_addr_reg;
                        wr_data = half_pre[32:1];
                    end
                    if ((kind_reg == hht_pkg::OP_MAX) && (rd_data_reg > acc_reg))
                    begin
                        acc_next = rd_data_reg;
                    end
                end
            end
            hht_pkg::BK_RESULT:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    load_data = (kind_reg == hht_pkg::OP_MAX) ? acc_reg : '0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign out_valid_next = load || (out_valid_reg && !m_tready);
    assign out_data_next  = load ? load_data : out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hht_pkg::BK_INIT;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        operand_reg   <= operand_next;
        addr_reg      <= addr_next;
        pend_addr_reg <= pend_addr_next;
        acc_reg       <= acc_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == hht_pkg::BK_IDLE))
        else $error("queue popped outside idle");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write to the same cell in one cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hht_pkg::BK_IDLE) |-> !pend_reg)
        else $error("sweep read left pending");

    a_max_floor: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == hht_pkg::BK_RESULT) && (kind_reg == hht_pkg::OP_MAX))
            |-> (acc_reg >= hht_pkg::MAX_FLOOR))
        else $error("maximum below floor");

endmodule
